@@ sv/solf_pkg.sv @@
package solf_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_CORNER    = 2'd2;
  localparam logic [1:0] REG_STEP_TIME = 2'd3;

  localparam int OP_W   = 33;  // shared multiplier operand width
  localparam int PROD_W = 64;  // kept product width
  localparam int SUM_W  = 42;  // width of the pre-saturation sums

  localparam logic [14:0] DAMP_ONE = 15'd16384;
  localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KX,
    ST_DV,
    ST_G,
    ST_ERR,
    ST_DVEL,
    ST_DLEV,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    state_t st;
    logic   ready;
    logic   load_out;
  } ctrl_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(SUM_W'(32'sh7FFF_FFFF))) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -$signed(SUM_W'(33'sh0_8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/second_order_lag_filter.sv @@
// second-order lag filter, one forward euler step per input beat
// steps: KX, DV, G, ERR, DVEL, DLEV, UPD, then OUT loads the result register once the
// output is free (bypass goes from IDLE straight to OUT); no new beat is taken before
// the sequencer returns to IDLE, since five products run one after another on the
// single shared 33x33 multiplier. reset: rst (synchronous) clears velocity and level and restores the register defaults
module second_order_lag_filter (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] filtered
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic signed [15:0] gain;
  logic signed [15:0] damping;
  logic signed [31:0] corner_frequency;
  logic        [23:0] step_time;

  // filter state
  logic signed [31:0] velocity;
  logic signed [31:0] level;

  // per-item scratch
  logic signed [31:0] sample_q;
  logic signed [40:0] kx;
  logic signed [40:0] dv2;
  logic signed [31:0] err;
  logic        [30:0] step_gain;
  logic signed [39:0] dvel;

  logic signed [solf_pkg::OP_W-1:0]   op_a, op_b;
  logic signed [solf_pkg::PROD_W-1:0] prod;
  logic        [14:0]                 damp_clamp;
  logic signed [solf_pkg::SUM_W-1:0]  err_sum, vel_sum, lev_sum;
  logic signed [39:0]                 dlev;
  logic                               bypass;
  logic                               out_free;
  logic                               s_accept;
  solf_pkg::ctrl_t                    ctl;

  assign bypass   = corner_frequency[31] || (corner_frequency == 32'sd0);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = ctl.ready;
  assign s_accept = s_tvalid && s_tready;

  solf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .bypass   (bypass),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // configuration port, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      gain             <= 16'sd256;
      damping          <= 16'sd16384;
      corner_frequency <= 32'sd65536;
      step_time        <= 24'd16777;
    end else if (cfg_we) begin
      case (cfg_index)
        solf_pkg::REG_GAIN:      gain             <= cfg_data[15:0];
        solf_pkg::REG_DAMPING:   damping          <= cfg_data[15:0];
        solf_pkg::REG_CORNER:    corner_frequency <= cfg_data;
        solf_pkg::REG_STEP_TIME: step_time        <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // damping limited to 0..1.0 in q2.14
  always_comb begin
    if (damping[15]) begin
      damp_clamp = 15'd0;
    end else if (damping[14] && (damping[13:0] != 14'd0)) begin
      damp_clamp = solf_pkg::DAMP_ONE;
    end else begin
      damp_clamp = damping[14:0];
    end
  end

  // operand select for the shared multiplier, product is registered and shows up in the next cycle
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctl.st)
      solf_pkg::ST_KX: begin
        op_a = {{17{gain[15]}}, gain};
        op_b = {sample_q[31], sample_q};
      end
      solf_pkg::ST_DV: begin
        op_a = {18'd0, damp_clamp};
        op_b = {velocity[31], velocity};
      end
      solf_pkg::ST_G: begin
        op_a = {corner_frequency[31], corner_frequency};
        op_b = {9'd0, step_time};
      end
      solf_pkg::ST_DVEL: begin
        op_a = {err[31], err};
        op_b = {2'd0, step_gain};
      end
      solf_pkg::ST_DLEV: begin
        op_a = {velocity[31], velocity};
        op_b = {2'd0, step_gain};
      end
      default: ;
    endcase
  end

  solf_mul u_mul (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  // error term k*x - y - 2*d*v, widened then clipped to 32 bits
  assign err_sum = $signed({kx[40], kx})
                 - $signed({{10{level[31]}}, level})
                 - $signed({dv2[40], dv2});

  // floor shift of w0*dt*v by 24 comes straight off the product
  assign dlev    = prod[63:24];
  assign vel_sum = $signed({{10{velocity[31]}}, velocity}) + $signed({{2{dvel[39]}}, dvel});
  assign lev_sum = $signed({{10{level[31]}}, level}) + $signed({{2{dlev[39]}}, dlev});

  // datapath registers; kx, dv2, step_gain and dvel capture the product of the previous step
  always_ff @(posedge clk) begin
    if (s_accept) begin
      sample_q <= s_tdata;
    end
    case (ctl.st)
      solf_pkg::ST_DV:  kx  <= prod[48:8];    // floor(k*x / 2^8)
      solf_pkg::ST_G:   dv2 <= prod[53:13];   // floor(d*v / 2^13), i.e. 2*d*v
      solf_pkg::ST_ERR: begin
        err <= solf_pkg::sat_s32(err_sum);
        // w0*dt in q7.24, clipped just below 128
        step_gain <= (prod[63:47] != 17'd0) ? solf_pkg::GAIN_MAX : prod[46:16];
      end
      solf_pkg::ST_DLEV: dvel <= prod[63:24];
      default: ;
    endcase
  end

  // filter state, both updates use the old velocity
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity <= '0;
      level    <= '0;
    end else if (s_accept && bypass) begin
      level <= s_tdata;
    end else if (ctl.st == solf_pkg::ST_UPD) begin
      velocity <= solf_pkg::sat_s32(vel_sum);
      level    <= solf_pkg::sat_s32(lev_sum);
    end
  end

  // output register, filled once the previous beat has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      m_tdata <= level;
    end
  end

`ifndef SYNTHESIS
  // bypass takes the sample as the new level
  a_bypass_level: assert property (@(posedge clk) disable iff (rst)
    (s_accept && bypass) |=> (level == $past(s_tdata)))
    else $error("bypass did not load the sample into level");

  // a new result beat only comes from the output step of the sequencer
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(ctl.st) == solf_pkg::ST_OUT))
    else $error("result beat raised outside the output step");

  // the loaded beat carries the current level
  a_out_level: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> (m_tvalid && (m_tdata == level)))
    else $error("result beat does not match level");
`endif

endmodule

@@ sv/solf_mul.sv @@
module solf_mul (
  input  logic                               clk,
  input  logic signed [solf_pkg::OP_W-1:0]   a,
  input  logic signed [solf_pkg::OP_W-1:0]   b,
  output logic signed [solf_pkg::PROD_W-1:0] prod
);

  logic signed [2*solf_pkg::OP_W-1:0] prod_full;

  assign prod_full = a * b;

  // every product in use fits in the low bits
  always_ff @(posedge clk) begin
    prod <= prod_full[solf_pkg::PROD_W-1:0];
  end

endmodule

@@ sv/solf_seq.sv @@
module solf_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            bypass,
  input  logic            out_free,
  output solf_pkg::ctrl_t ctl
);

  solf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= solf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl.st       = state;
    ctl.ready    = 1'b0;
    ctl.load_out = 1'b0;
    case (state)
      solf_pkg::ST_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) begin
          state_next = bypass ? solf_pkg::ST_OUT : solf_pkg::ST_KX;
        end
      end
      solf_pkg::ST_KX:   state_next = solf_pkg::ST_DV;
      solf_pkg::ST_DV:   state_next = solf_pkg::ST_G;
      solf_pkg::ST_G:    state_next = solf_pkg::ST_ERR;
      solf_pkg::ST_ERR:  state_next = solf_pkg::ST_DVEL;
      solf_pkg::ST_DVEL: state_next = solf_pkg::ST_DLEV;
      solf_pkg::ST_DLEV: state_next = solf_pkg::ST_UPD;
      solf_pkg::ST_UPD:  state_next = solf_pkg::ST_OUT;
      solf_pkg::ST_OUT: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = solf_pkg::ST_IDLE;
        end
      end
      default: state_next = solf_pkg::ST_IDLE;
    endcase
  end

endmodule
